FILE: sv/multi_shape_wave_generator_macros.svh
// Assertion macros for the multi-shape wave generator checker.
// Used by the bound checker module only.
`ifndef MULTI_SHAPE_WAVE_GENERATOR_MACROS_SVH
`define MULTI_SHAPE_WAVE_GENERATOR_MACROS_SVH

// Implication checked only outside reset.
`define MSWG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked also during reset.
`define MSWG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/mswg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the wave generator.
// No dependencies.
`default_nettype none
package mswg_pkg;

    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int QN                 = SINE_TABLE_ENTRIES / 4;
    localparam int IDX_W              = $clog2(SINE_TABLE_ENTRIES);
    localparam int QN_W               = $clog2(QN);
    localparam int SV_W               = 17;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [SV_W-1:0] t_tab [0:QN];

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_TRIANGLE = 2'd2,
        SHAPE_RANDOM   = 2'd3
    } t_shape;

    typedef enum logic [2:0] {
        REG_SHAPE  = 3'd0,
        REG_PERIOD = 3'd1,
        REG_DUTY   = 3'd2,
        REG_PHASE  = 3'd3,
        REG_STEP   = 3'd4,
        REG_AMP    = 3'd5,
        REG_OFFSET = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TMOD,
        ST_PMOD,
        ST_POS,
        ST_IDX,
        ST_MLOAD,
        ST_MUL,
        ST_SCALE,
        ST_TDIV,
        ST_SUM,
        ST_DONE
    } t_state;

    // Restoring long division, used only while the table is elaborated.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Integer Taylor series in Q30, rounded to Q16.
    function automatic t_tab build_tab();
        t_tab tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        longint v;
        for (int k = 0; k <= QN; k++) begin
            x    = (HALF_PI_Q30 * longint'(k)) >> QN_W;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = div_u64((term * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
                if (n[0]) sum = sum - longint'(term);
                else      sum = sum + longint'(term);
            end
            v = (sum + 8192) >>> 14;
            if (v > 65536) v = 65536;
            if (v < 0) v = 0;
            tab[k] = v[SV_W-1:0];
        end
        return tab;
    endfunction

    localparam t_tab SINE_TAB = build_tab();

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        if (v > 67'sd2147483647)       return 32'sh7fffffff;
        else if (v < -67'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: sv/multi_shape_wave_generator.sv
// Multi-shape wave generator top level: config registers, sequencer, datapath.
// Depends on mswg_pkg and mswg_div.
//
//  channel   dir  handshake                   payload
//  s         in   i_s_tvalid / o_s_tready     i_s_tdata[7:0]  : restart, random_bit
//  m         out  o_m_tvalid / i_m_tready     o_m_tdata[95:0] : sample, sample_time
//  cfg       in   i_cfg_we (no wait)          i_cfg_addr, i_cfg_wdata
//
// A sample uses two divisions of the serial divider (square, random) or three (sine,
// triangle); sine and triangle also pass through a load state and the serial
// multiplier. A triangle with a zero quarter period skips its third division and
// the multiplier.
// Reset is synchronous, active low; it restores register defaults and time zero.
// A finished sample waits in the output register; the next beat is taken meanwhile
// and its result is held back until the output register is free.
`default_nettype none
module multi_shape_wave_generator import mswg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [0] restart, [1] random_bit, [7:2] zero
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [95:0]      o_m_tdata,   // [31:0] sample, [94:32] sample_time, [95] zero
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);

    t_state r_state, n_state;

    t_shape             r_shape;
    logic [31:0]        r_period, r_duty, r_step;
    logic signed [31:0] r_phase, r_amp, r_off;

    logic [63:0]        r_time, r_last;
    logic signed [31:0] r_held, r_res;
    logic               r_rbit;
    logic [31:0]        r_tm, r_pos;
    logic signed [33:0] r_num;
    logic signed [65:0] r_acc;
    logic [31:0]        r_mul_hi, r_mul_lo;
    logic [4:0]         r_mcnt;
    logic               r_mneg;
    logic               r_ovalid;
    logic [95:0]        r_odata;

    logic        w_in_acc, w_out_free;
    logic        w_div_start, w_div_done;
    logic [63:0] w_div_dvd, w_div_quot;
    logic [31:0] w_div_dsr, w_div_rem;

    logic [31:0]        w_p, w_q, w_phabs, w_pos;
    logic [32:0]        w_t;
    logic signed [33:0] w_q34, w_pos34, w_num;
    logic [IDX_W-1:0]   w_idx;
    logic [QN_W:0]      w_tidx;
    logic signed [SV_W:0] w_sv;
    logic [31:0]        w_amag, w_nabs;
    logic [32:0]        w_madd;
    logic signed [65:0] w_prod;
    logic [63:0]        w_diff;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ovalid || i_m_tready;

    assign w_p     = (r_period == 32'd0) ? 32'd1 : r_period;
    assign w_q     = w_p >> 2;
    assign w_phabs = r_phase[31] ? (~r_phase + 32'd1) : r_phase;

    // Fold the phase residue into the time residue; one subtract brings it back.
    always_comb begin
        if (!r_phase[31]) w_t = {1'b0, r_tm} + {1'b0, w_p} - {1'b0, w_div_rem};
        else              w_t = {1'b0, r_tm} + {1'b0, w_div_rem};
        if (w_t >= {1'b0, w_p}) w_pos = w_t[31:0] - w_p;
        else                    w_pos = w_t[31:0];
    end

    assign w_q34   = signed'({2'b00, w_q});
    assign w_pos34 = signed'({2'b00, r_pos});
    always_comb begin
        if (w_pos34 < w_q34)           w_num = w_pos34;
        else if (w_pos34 < 3 * w_q34)  w_num = 2 * w_q34 - w_pos34;
        else                           w_num = w_pos34 - 4 * w_q34;
    end

    assign w_idx  = w_div_quot[IDX_W-1:0];
    assign w_tidx = w_idx[IDX_W-2] ? ((QN_W+1)'(QN) - {1'b0, w_idx[QN_W-1:0]})
                                   : {1'b0, w_idx[QN_W-1:0]};
    assign w_sv   = w_idx[IDX_W-1] ? -signed'({1'b0, SINE_TAB[w_tidx]})
                                   :  signed'({1'b0, SINE_TAB[w_tidx]});

    // Shift-add multiplier on magnitudes, one multiplier bit a cycle.
    assign w_amag = r_amp[31] ? (~r_amp + 32'd1) : r_amp;
    assign w_nabs = r_num[33] ? 32'(-r_num) : r_num[31:0];
    assign w_madd = {1'b0, r_mul_hi} + (r_mul_lo[0] ? {1'b0, w_amag} : 33'd0);
    assign w_prod = r_mneg ? -signed'({2'b00, r_mul_hi, r_mul_lo})
                           :  signed'({2'b00, r_mul_hi, r_mul_lo});

    assign w_diff = r_time - r_last;

    mswg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc) n_state = ST_TMOD;
            ST_TMOD:  if (w_div_done) n_state = ST_PMOD;
            ST_PMOD:  if (w_div_done) n_state = ST_POS;
            ST_POS: begin
                unique case (r_shape)
                    SHAPE_SINE:     n_state = ST_IDX;
                    SHAPE_SQUARE:   n_state = ST_SUM;
                    SHAPE_TRIANGLE: n_state = (w_q == 32'd0) ? ST_SUM : ST_MLOAD;
                    default:        n_state = ST_DONE;
                endcase
            end
            ST_IDX:   if (w_div_done) n_state = ST_MLOAD;
            ST_MLOAD: n_state = ST_MUL;
            ST_MUL:   if (r_mcnt == 5'd31) n_state = ST_SCALE;
            ST_SCALE: n_state = (r_shape == SHAPE_SINE) ? ST_SUM : ST_TDIV;
            ST_TDIV:  if (w_div_done) n_state = ST_SUM;
            ST_SUM:   n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: input ready and divider requests.
    always_comb begin
        o_s_tready  = 1'b0;
        w_div_start = 1'b0;
        w_div_dvd   = '0;
        w_div_dsr   = w_p;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                w_div_start = w_in_acc;
                w_div_dvd   = i_s_tdata[0] ? 64'd0 : r_time;
            end
            ST_TMOD: begin
                w_div_start = w_div_done;
                w_div_dvd   = {32'd0, w_phabs};
            end
            ST_POS: begin
                w_div_start = (r_shape == SHAPE_SINE);
                w_div_dvd   = {{(32-IDX_W){1'b0}}, r_pos, {IDX_W{1'b0}}};
            end
            ST_SCALE: begin
                w_div_start = (r_shape == SHAPE_TRIANGLE);
                w_div_dvd   = {r_mul_hi, r_mul_lo};
                w_div_dsr   = w_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_shape  <= SHAPE_SINE;
            r_period <= 32'd1000000000;
            r_duty   <= 32'd500000000;
            r_phase  <= '0;
            r_step   <= 32'd1000000;
            r_amp    <= 32'sd65536;
            r_off    <= '0;
            r_time   <= '0;
            r_last   <= '0;
            r_held   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SHAPE:  r_shape  <= t_shape'(i_cfg_wdata[1:0]);
                    REG_PERIOD: r_period <= i_cfg_wdata;
                    REG_DUTY:   r_duty   <= i_cfg_wdata;
                    REG_PHASE:  r_phase  <= i_cfg_wdata;
                    REG_STEP:   r_step   <= i_cfg_wdata;
                    REG_AMP:    r_amp    <= i_cfg_wdata;
                    REG_OFFSET: r_off    <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == ST_DONE && w_out_free) r_ovalid <= 1'b1;
            else if (r_ovalid && i_m_tready)      r_ovalid <= 1'b0;
            if (r_state == ST_IDLE && w_in_acc && i_s_tdata[0]) begin
                r_time <= '0;
                r_last <= '0;
            end
            if (r_state == ST_POS && r_shape == SHAPE_RANDOM
                && w_diff > {32'd0, w_p}) begin
                r_held <= r_rbit ? sat32(67'(r_amp) + 67'(r_off)) : r_off;
                r_last <= r_time;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_time   <= r_time + {32'd0, r_step};
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (w_in_acc) r_rbit <= i_s_tdata[1];
            ST_TMOD: if (w_div_done) r_tm <= w_div_rem;
            ST_PMOD: if (w_div_done) r_pos <= w_pos;
            ST_POS: begin
                if (r_shape == SHAPE_SQUARE)
                    r_acc <= (r_pos < r_duty) ? 66'(r_amp) : -66'(r_amp);
                else
                    r_acc <= '0;
                r_num <= w_num;
            end
            ST_IDX:   if (w_div_done) r_num <= 34'(w_sv);
            ST_MLOAD: begin
                r_mul_hi <= '0;
                r_mul_lo <= w_nabs;
                r_mcnt   <= '0;
                r_mneg   <= r_amp[31] ^ r_num[33];
            end
            ST_MUL: begin
                r_mul_hi <= w_madd[32:1];
                r_mul_lo <= {w_madd[0], r_mul_lo[31:1]};
                r_mcnt   <= r_mcnt + 5'd1;
            end
            ST_SCALE: r_acc <= w_prod >>> 16;
            ST_TDIV: begin
                if (w_div_done) begin
                    if (r_mneg)
                        r_acc <= -signed'({2'b00, w_div_quot})
                                 - 66'(w_div_rem != 32'd0);
                    else
                        r_acc <= signed'({2'b00, w_div_quot});
                end
            end
            ST_SUM: r_res <= sat32(67'(r_acc) + 67'(r_off));
            ST_DONE: begin
                if (w_out_free)
                    r_odata <= {1'b0, r_time[62:0],
                                (r_shape == SHAPE_RANDOM) ? r_held : r_res};
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule
`default_nettype wire

FILE: sv/mswg_div.sv
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Uses mswg_pkg only for house consistency of imports.
`default_nettype none
module mswg_div import mswg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quot,
    output logic [31:0]      o_rem
);

    logic [63:0] r_dvd;
    logic [31:0] r_rem;
    logic [31:0] r_dsr;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;
    logic        w_ge;
    logic [32:0] w_diff;

    assign w_trial = {r_rem, r_dvd[63]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift the quotient bits in behind the dividend bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
            r_dvd <= {r_dvd[62:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

FILE: sv/mswg_checker.sv
// Port-level checker for the wave generator, bound to the top level.
// Depends on multi_shape_wave_generator_macros.svh.
`default_nettype none
`include "multi_shape_wave_generator_macros.svh"
module mswg_port_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [95:0] o_m_tdata
);

    `MSWG_ASSERT_IMP(a_hold, o_m_tvalid && !i_m_tready, ##1 (o_m_tvalid && $stable(o_m_tdata)))
    `MSWG_ASSERT_NEXT(a_rst_quiet, !i_rst_n, !o_m_tvalid)
    `MSWG_ASSERT_IMP(a_one_at_a_time, i_s_tvalid && o_s_tready, ##1 !o_s_tready)
    `MSWG_ASSERT_IMP(a_pad_zero, o_m_tvalid, !o_m_tdata[95])

endmodule

bind multi_shape_wave_generator mswg_port_checker u_mswg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire
